@@ src/mbd_pkg.sv @@
package mbd_pkg;

   localparam int NUM_BUTTONS_DEFAULT = 4;

   // fixed field widths
   localparam int PIN_W     = 4;
   localparam int TICK_W    = 32;
   localparam int MS_W      = 16;
   localparam int QUERY_W   = 2;
   localparam int CSR_IDX_W = 1;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLARITY    = 1'd1;

   localparam logic [MS_W-1:0]  DEBOUNCE_MS_RESET = 16'd25;
   localparam logic [PIN_W-1:0] POLARITY_RESET    = 4'hF;

   typedef struct packed {
      logic pressed;
      logic new_press;
      logic debouncing;
      logic hold_ok;
   } lane_status_type;

   typedef struct packed {
      logic             held;
      logic [PIN_W-1:0] debouncing_mask;
      logic [PIN_W-1:0] new_press_mask;
      logic [PIN_W-1:0] pressed_mask;
   } result_type;

endpackage

@@ src/multi_button_debouncer.sv @@
// Channel    Ports         Dir  Payload (lowest bit up)
// request    req_t*        in   pin_levels, edge_mask, ack_mask, query_button, hold_ms
// response   rsp_t*        out  pressed_mask, new_press_mask, debouncing_mask, held
// config     csr_*         in   0 debounce_ms, 1 polarity mask (1 = pressed when low)
//
// One tick per request transfer: all buttons are updated by parallel lanes
// in the cycle of the transfer; the result goes to the output register,
// or to the skid entry if the output stalls. An output register plus one
// skid entry let a new request transfer while a result waits. Synchronous
// active-high reset clears the tick counter, all button flags and the
// output buffer; config regs return to 25 ms and buttons 0-3 active low.
module multi_button_debouncer #(
   parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [3:0] pin_levels, [7:4] edge_mask, [11:8] ack_mask,
   // [13:12] query_button, [29:14] hold_ms, [31:30] zero
   input  logic [mbd_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [3:0] pressed_mask, [7:4] new_press_mask, [11:8] debouncing_mask,
   // [12] held, [15:13] zero
   output logic [mbd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [mbd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbd_pkg::MS_W-1:0]       csr_wdata
);
   import mbd_pkg::*;

   localparam int ExtW = (NUM_BUTTONS > PIN_W) ? NUM_BUTTONS : PIN_W;

   // config registers
   logic [MS_W-1:0]  debounce_ms_ff;
   logic [PIN_W-1:0] polarity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= DEBOUNCE_MS_RESET;
         polarity_ff    <= POLARITY_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE_MS: debounce_ms_ff <= csr_wdata;
            CSR_POLARITY:    polarity_ff    <= csr_wdata[PIN_W-1:0];
            default: ;
         endcase
      end
   end

   // request fields
   logic [PIN_W-1:0]   pin_levels, edge_mask, ack_mask;
   logic [QUERY_W-1:0] query_button;
   logic [MS_W-1:0]    hold_ms;

   assign pin_levels   = req_tdata[3:0];
   assign edge_mask    = req_tdata[7:4];
   assign ack_mask     = req_tdata[11:8];
   assign query_button = req_tdata[13:12];
   assign hold_ms      = req_tdata[29:14];

   // buttons past the fourth get no pin, edge or ack bits
   logic [ExtW-1:0] pin_ext, edge_ext, ack_ext, low_ext;
   assign pin_ext  = ExtW'(pin_levels);
   assign edge_ext = ExtW'(edge_mask);
   assign ack_ext  = ExtW'(ack_mask);
   assign low_ext  = ExtW'(polarity_ff);

   logic req_xfer;
   assign req_xfer = req_tvalid & req_tready;

   // running tick count, one per request transfer
   logic [TICK_W-1:0] tick_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (req_xfer) begin
         tick_ff <= tick_ff + 1'b1;
      end
   end

   lane_status_type lane_status [NUM_BUTTONS];

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      mbd_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .accept      (req_xfer),
         .tick        (tick_ff),
         .debounce_ms (debounce_ms_ff),
         .low_true    (low_ext[g]),
         .pin         (pin_ext[g]),
         .edge_seen   (edge_ext[g]),
         .ack         (ack_ext[g]),
         .hold_ms     (hold_ms),
         .status      (lane_status[g])
      );
   end

   result_type result;

   mbd_merge #(
      .NumButtons (NUM_BUTTONS)
   ) u_merge (
      .lane_status  (lane_status),
      .query_button (query_button),
      .result       (result)
   );

   // output register plus skid entry
   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       out_free;

   assign req_tready = ~skid_valid_ff;
   assign out_free   = ~out_valid_ff | rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else if (req_xfer) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (req_xfer) begin
         // result waits behind a stalled output
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.held, out_ff.debouncing_mask,
                        out_ff.new_press_mask, out_ff.pressed_mask};

endmodule

@@ src/mbd_lane.sv @@
module mbd_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  logic [mbd_pkg::TICK_W-1:0] tick,
   input  logic [mbd_pkg::MS_W-1:0]   debounce_ms,
   input  logic                       low_true,
   input  logic                       pin,
   input  logic                       edge_seen,
   input  logic                       ack,
   input  logic [mbd_pkg::MS_W-1:0]   hold_ms,
   output mbd_pkg::lane_status_type   status
);
   import mbd_pkg::*;

   logic              active_ff, active_in;
   logic              pressed_ff, pressed_in;
   logic              latched_ff, latched_in;
   logic [TICK_W-1:0] start_ff, start_in;

   logic              latch_acked;
   logic              opened;
   logic [TICK_W-1:0] elapsed;
   logic              close;
   logic              level_now;

   always_comb begin
      latch_acked = latched_ff & ~ack;
      opened      = edge_seen & ~active_ff;
      start_in    = opened ? tick : start_ff;
      elapsed     = tick - start_in;
      close       = (active_ff | opened) && (elapsed >= {{(TICK_W-MS_W){1'b0}}, debounce_ms});
      level_now   = pin ^ low_true;

      active_in  = (active_ff | opened) & ~close;
      pressed_in = close ? level_now : pressed_ff;
      latched_in = latch_acked | (close & level_now & ~pressed_ff);

      status.pressed    = pressed_in;
      status.new_press  = latched_in;
      status.debouncing = active_in;
      status.hold_ok    = pressed_in && (elapsed >= {{(TICK_W-MS_W){1'b0}}, hold_ms});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         pressed_ff <= 1'b0;
         latched_ff <= 1'b0;
      end else if (accept) begin
         active_ff  <= active_in;
         pressed_ff <= pressed_in;
         latched_ff <= latched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         start_ff <= start_in;
      end
   end

endmodule

@@ src/mbd_merge.sv @@
module mbd_merge #(
   parameter int NumButtons = mbd_pkg::NUM_BUTTONS_DEFAULT
) (
   input  mbd_pkg::lane_status_type     lane_status [NumButtons],
   input  logic [mbd_pkg::QUERY_W-1:0]  query_button,
   output mbd_pkg::result_type          result
);
   import mbd_pkg::*;

   localparam int ExtW = (NumButtons > PIN_W) ? NumButtons : PIN_W;

   logic [ExtW-1:0] pressed_ext;
   logic [ExtW-1:0] new_press_ext;
   logic [ExtW-1:0] debouncing_ext;
   logic [ExtW-1:0] hold_ext;

   // lanes past NumButtons read as zero, so an out-of-range query gives not held
   always_comb begin
      pressed_ext    = '0;
      new_press_ext  = '0;
      debouncing_ext = '0;
      hold_ext       = '0;
      for (int i = 0; i < NumButtons; i++) begin
         pressed_ext[i]    = lane_status[i].pressed;
         new_press_ext[i]  = lane_status[i].new_press;
         debouncing_ext[i] = lane_status[i].debouncing;
         hold_ext[i]       = lane_status[i].hold_ok;
      end
      result.pressed_mask    = pressed_ext[PIN_W-1:0];
      result.new_press_mask  = new_press_ext[PIN_W-1:0];
      result.debouncing_mask = debouncing_ext[PIN_W-1:0];
      result.held            = hold_ext[query_button];
   end

endmodule
